// ===== design/msp_pkg.sv =====
package msp_pkg;

    localparam int AddrW = 5;

    localparam logic [11:0] TargetMax   = 12'd2700;
    localparam logic [11:0] TargetReset = 12'd2000;
    localparam logic signed [10:0] GainPropReset  = 11'sd3;
    localparam logic signed [10:0] GainIntegReset = 11'sd0;
    localparam logic signed [10:0] GainDerivReset = 11'sd0;
    localparam logic [14:0] WindupReset = 15'd250;
    localparam logic [15:0] DampReset   = 16'd100;
    localparam logic [15:0] LevelReset  = 16'h8000;
    localparam logic [15:0] LevelMax    = 16'hFFFF;
    localparam logic [30:0] RecipFive   = 31'h6666_6667;

    typedef enum logic [2:0] {
        REG_TARGET = 3'd0,
        REG_GAIN_P = 3'd1,
        REG_GAIN_I = 3'd2,
        REG_GAIN_D = 3'd3,
        REG_WINDUP = 3'd4,
        REG_DAMP   = 3'd5
    } reg_idx_t;

    typedef struct packed {
        logic [11:0]        target_speed;
        logic signed [10:0] gain_prop;
        logic signed [10:0] gain_integ;
        logic signed [10:0] gain_deriv;
        logic [14:0]        windup_limit;
        logic [15:0]        damp_threshold;
    } cfg_t;

endpackage

// ===== design/motor_speed_pid_unit.sv =====
// Speed PID controller: one measured speed request is accepted per clock cycle while
// meas_stall is low, and its new drive level appears after passing through the input register and the
// register stages (error and integral, products, sum, damping, level). The
// integral and drive level feedback each close within a single stage, so back-to-back
// requests are fully supported; output stall backs up through the stages only when
// every stage is occupied. Registers sit on an APB port at byte addresses 0x00 to 0x14
// and must be written only while no request is in flight.
module motor_speed_pid_unit (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [msp_pkg::AddrW-1:0]  paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    input  logic                       meas_valid,
    output logic                       meas_stall,
    input  logic [15:0]                measured_speed,
    output logic                       drive_valid,
    input  logic                       drive_stall,
    output logic [15:0]                drive_level
);
    import msp_pkg::*;

    cfg_t cfg;

    logic rdy_a, rdy_b, rdy_c, rdy_d, rdy_e, rdy_o;

    logic               a_vld_reg;
    logic [15:0]        a_meas_reg;
    logic               b_vld_reg;
    logic signed [17:0] b_err_reg;
    logic signed [15:0] b_integ_reg;
    logic signed [17:0] b_deriv_reg;
    logic               c_vld_reg;
    logic signed [28:0] c_p_reg;
    logic signed [26:0] c_i_reg;
    logic signed [28:0] c_d_reg;
    logic               c_damp_reg;
    logic               d_vld_reg;
    logic               d_neg_reg;
    logic [27:0]        d_mag_reg;
    logic               d_damp_reg;
    logic               e_vld_reg;
    logic signed [28:0] e_corr_reg;
    logic               o_vld_reg;
    logic [15:0]        drive_level_reg;

    logic signed [15:0] integ_acc_reg;
    logic signed [17:0] last_err_reg;
    logic [15:0]        duty_reg;

    logic signed [17:0] err_a;
    logic signed [18:0] integ_sum;
    logic signed [18:0] lim;
    logic signed [15:0] integ_next;
    logic signed [18:0] deriv_wide;
    logic [17:0]        err_mag;
    logic               damp_b;
    logic signed [28:0] p_b;
    logic signed [26:0] i_b;
    logic signed [28:0] d_b;
    logic signed [28:0] corr_c;
    logic [27:0]        scaled;
    logic signed [28:0] corr_d;
    logic signed [29:0] lvl_e;
    logic [15:0]        duty_next;

    msp_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign rdy_o = !o_vld_reg || !drive_stall;
    assign rdy_e = !e_vld_reg || rdy_o;
    assign rdy_d = !d_vld_reg || rdy_e;
    assign rdy_c = !c_vld_reg || rdy_d;
    assign rdy_b = !b_vld_reg || rdy_c;
    assign rdy_a = !a_vld_reg || rdy_b;

    assign meas_stall  = !rdy_a;
    assign drive_valid = o_vld_reg;
    assign drive_level = drive_level_reg;

    assign err_a      = $signed({6'd0, cfg.target_speed}) - $signed({2'd0, a_meas_reg});
    assign integ_sum  = 19'(integ_acc_reg) + 19'(err_a);
    assign lim        = $signed({4'd0, cfg.windup_limit});
    assign deriv_wide = 19'(err_a) - 19'(last_err_reg);

    always_comb
    begin
        if (integ_sum > lim)
        begin
            integ_next = lim[15:0];
        end
        else if (integ_sum < -lim)
        begin
            integ_next = 16'(-lim);
        end
        else
        begin
            integ_next = integ_sum[15:0];
        end
    end

    assign err_mag = b_err_reg[17] ? 18'(-b_err_reg) : 18'(b_err_reg);
    assign damp_b  = err_mag < {2'd0, cfg.damp_threshold};
    assign p_b     = 29'(cfg.gain_prop) * 29'(b_err_reg);
    assign i_b     = 27'(cfg.gain_integ) * 27'(b_integ_reg);
    assign d_b     = 29'(cfg.gain_deriv) * 29'(b_deriv_reg);

    assign corr_c = c_p_reg + 29'(c_i_reg) - c_d_reg;

    msp_scale u_scale (
        .mag  (d_mag_reg),
        .damp (d_damp_reg),
        .res  (scaled)
    );

    assign corr_d = d_neg_reg ? -$signed({1'b0, scaled}) : $signed({1'b0, scaled});

    assign lvl_e = $signed({14'd0, duty_reg}) + 30'(e_corr_reg);

    always_comb
    begin
        if (lvl_e < 30'sd0)
        begin
            duty_next = 16'd0;
        end
        else if (lvl_e > $signed({14'd0, LevelMax}))
        begin
            duty_next = LevelMax;
        end
        else
        begin
            duty_next = lvl_e[15:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg     <= 1'b0;
            b_vld_reg     <= 1'b0;
            c_vld_reg     <= 1'b0;
            d_vld_reg     <= 1'b0;
            e_vld_reg     <= 1'b0;
            o_vld_reg     <= 1'b0;
            integ_acc_reg <= '0;
            last_err_reg  <= '0;
            duty_reg      <= LevelReset;
        end
        else
        begin
            if (rdy_a)
            begin
                a_vld_reg <= meas_valid;
            end
            if (rdy_b)
            begin
                b_vld_reg <= a_vld_reg;
            end
            if (rdy_c)
            begin
                c_vld_reg <= b_vld_reg;
            end
            if (rdy_d)
            begin
                d_vld_reg <= c_vld_reg;
            end
            if (rdy_e)
            begin
                e_vld_reg <= d_vld_reg;
            end
            if (rdy_o)
            begin
                o_vld_reg <= e_vld_reg;
            end
            if (a_vld_reg && rdy_b)
            begin
                integ_acc_reg <= integ_next;
                last_err_reg  <= err_a;
            end
            if (e_vld_reg && rdy_o)
            begin
                duty_reg <= duty_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy_a)
        begin
            a_meas_reg <= measured_speed;
        end
        if (rdy_b)
        begin
            b_err_reg   <= err_a;
            b_integ_reg <= integ_next;
            b_deriv_reg <= deriv_wide[17:0];
        end
        if (rdy_c)
        begin
            c_p_reg    <= p_b;
            c_i_reg    <= i_b;
            c_d_reg    <= d_b;
            c_damp_reg <= damp_b;
        end
        if (rdy_d)
        begin
            d_neg_reg  <= corr_c[28];
            d_mag_reg  <= corr_c[28] ? 28'(-corr_c) : corr_c[27:0];
            d_damp_reg <= c_damp_reg;
        end
        if (rdy_e)
        begin
            e_corr_reg <= corr_d;
        end
        if (rdy_o)
        begin
            drive_level_reg <= duty_next;
        end
    end

    a_level_tracks_state: assert property (@(posedge clk) disable iff (!rst_n)
        e_vld_reg && rdy_o |=> drive_level_reg == duty_reg)
        else $error("Delivered drive level differs from the stored duty level.");

    a_integ_in_limit: assert property (@(posedge clk) disable iff (!rst_n)
        b_vld_reg |-> (b_integ_reg <= $signed({1'b0, cfg.windup_limit}))
                   && (b_integ_reg >= -$signed({1'b0, cfg.windup_limit})))
        else $error("Integral term escaped the windup limit.");

    a_no_stall_through: assert property (@(posedge clk) disable iff (!rst_n)
        !drive_stall |-> !meas_stall)
        else $error("Input stalled although the output side is free.");

    a_damp_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        d_vld_reg |-> scaled <= d_mag_reg)
        else $error("Damping increased the correction magnitude.");

endmodule

// ===== design/msp_cfg.sv =====
module msp_cfg (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [msp_pkg::AddrW-1:0]  paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    output msp_pkg::cfg_t              cfg
);
    import msp_pkg::*;

    logic [11:0]        target_reg;
    logic signed [10:0] gain_p_reg;
    logic signed [10:0] gain_i_reg;
    logic signed [10:0] gain_d_reg;
    logic [14:0]        windup_reg;
    logic [15:0]        damp_reg;
    reg_idx_t           idx;
    logic               wr_en;

    assign idx    = reg_idx_t'(paddr[4:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg <= TargetReset;
            gain_p_reg <= GainPropReset;
            gain_i_reg <= GainIntegReset;
            gain_d_reg <= GainDerivReset;
            windup_reg <= WindupReset;
            damp_reg   <= DampReset;
        end
        else if (wr_en)
        begin
            case (idx)
                REG_TARGET: target_reg <= (pwdata[11:0] > TargetMax) ? TargetMax : pwdata[11:0];
                REG_GAIN_P: gain_p_reg <= $signed(pwdata[10:0]);
                REG_GAIN_I: gain_i_reg <= $signed(pwdata[10:0]);
                REG_GAIN_D: gain_d_reg <= $signed(pwdata[10:0]);
                REG_WINDUP: windup_reg <= pwdata[14:0];
                REG_DAMP:   damp_reg   <= pwdata[15:0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_TARGET: prdata = {20'd0, target_reg};
            REG_GAIN_P: prdata = 32'(gain_p_reg);
            REG_GAIN_I: prdata = 32'(gain_i_reg);
            REG_GAIN_D: prdata = 32'(gain_d_reg);
            REG_WINDUP: prdata = {17'd0, windup_reg};
            REG_DAMP:   prdata = {16'd0, damp_reg};
            default:    prdata = 32'd0;
        endcase
    end

    assign cfg.target_speed   = target_reg;
    assign cfg.gain_prop      = gain_p_reg;
    assign cfg.gain_integ     = gain_i_reg;
    assign cfg.gain_deriv     = gain_d_reg;
    assign cfg.windup_limit   = windup_reg;
    assign cfg.damp_threshold = damp_reg;

    a_target_range: assert property (@(posedge clk) disable iff (!rst_n)
        target_reg <= TargetMax)
        else $error("Stored target speed is above its maximum.");

endmodule

// ===== design/msp_scale.sv =====
module msp_scale (
    input  logic [27:0] mag,
    input  logic        damp,
    output logic [27:0] res
);
    import msp_pkg::*;

    // The reciprocal of five is exact to the floor for every value below 2**30.
    logic [29:0] num;
    logic [60:0] prod;

    assign num  = {mag, 2'b00};
    assign prod = 61'(num) * 61'(RecipFive);
    assign res  = damp ? prod[60:33] : mag;

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

    import msp_pkg::*;

    localparam int ClkPeriod = 8;
    localparam int ResetCycles = 9;
    localparam int MaxGap = 13;
    localparam int IdleCycles = 8;
    localparam int DrainCycles = 20;
    localparam int CycleLimit = 500000;
    localparam int RandomPhases = 20;
    localparam int PhaseRequests = 50;
    localparam int HoldOffCycles = 300;
    localparam int BurstRequests = 40;
    localparam logic [2:0] RegSpareLo = 3'd6;
    localparam logic [2:0] RegSpareHi = 3'd7;

    logic clk;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [AddrW-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;
    logic meas_valid;
    logic meas_stall;
    logic [15:0] measured_speed;
    logic drive_valid;
    logic drive_stall;
    logic [15:0] drive_level;

    cfg_t model_cfg;
    logic signed [15:0] model_integral;
    logic signed [17:0] model_last_error;
    logic [15:0] model_duty;

    logic [15:0] pending_levels[$];
    logic [15:0] want_level;
    int fault_count;
    int cycle_count;
    int send_max_gap;
    int recv_max_gap;
    int hold_request;

    motor_speed_pid_unit dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .meas_valid     (meas_valid),
        .meas_stall     (meas_stall),
        .measured_speed (measured_speed),
        .drive_valid    (drive_valid),
        .drive_stall    (drive_stall),
        .drive_level    (drive_level)
    );

    always #(ClkPeriod / 2) clk = ~clk;

    function automatic logic [15:0] next_drive_level(input logic [15:0] speed);
        longint err;
        longint acc;
        longint lim;
        longint slope;
        longint corr;
        longint mag;
        longint lvl;
        err = longint'(model_cfg.target_speed) - longint'(speed);
        lim = longint'(model_cfg.windup_limit);
        acc = longint'(model_integral) + err;
        if (acc > lim)
        begin
            acc = lim;
        end
        else if (acc < -lim)
        begin
            acc = -lim;
        end
        slope = err - longint'(model_last_error);
        corr = longint'($signed(model_cfg.gain_prop)) * err
             + longint'($signed(model_cfg.gain_integ)) * acc
             - longint'($signed(model_cfg.gain_deriv)) * slope;
        mag = (err < 0) ? -err : err;
        if (mag < longint'(model_cfg.damp_threshold))
        begin
            corr = (corr * 4) / 5;
        end
        lvl = longint'(model_duty) + corr;
        if (lvl > longint'(LevelMax))
        begin
            lvl = longint'(LevelMax);
        end
        else if (lvl < 0)
        begin
            lvl = 0;
        end
        model_integral = acc[15:0];
        model_last_error = err[17:0];
        model_duty = lvl[15:0];
        return lvl[15:0];
    endfunction

    function automatic int pick_setting(input int lo, input int hi, input int near_lo,
                                        input int near_hi);
        case ($urandom_range(0, 9))
            0: return lo;
            1: return hi;
            2: return lo + int'($urandom_range(0, hi - lo));
            default: return near_lo + int'($urandom_range(0, near_hi - near_lo));
        endcase
    endfunction

    function automatic logic [15:0] random_speed();
        int center;
        int spread;
        int lo;
        center = int'(model_cfg.target_speed);
        case ($urandom_range(0, 3))
            0: return 16'($urandom_range(0, 65535));
            1: spread = (model_cfg.damp_threshold > 3000) ? 3000 : int'(model_cfg.damp_threshold) + 1;
            default: spread = 400;
        endcase
        lo = (center > spread) ? center - spread : 0;
        return 16'(lo + int'($urandom_range(0, 2 * spread)));
    endfunction

    task automatic write_reg(input logic [2:0] idx, input int value);
        logic [31:0] mask;
        logic [31:0] data;
        case (idx)
            REG_TARGET: mask = 32'h0000_0FFF;
            REG_GAIN_P, REG_GAIN_I, REG_GAIN_D: mask = 32'h0000_07FF;
            REG_WINDUP: mask = 32'h0000_7FFF;
            default: mask = 32'h0000_FFFF;
        endcase
        data = ($urandom() & ~mask) | (32'(value) & mask);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
        begin
            @(posedge clk);
        end
        psel <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_TARGET: model_cfg.target_speed = (data[11:0] > TargetMax) ? TargetMax : data[11:0];
            REG_GAIN_P: model_cfg.gain_prop = data[10:0];
            REG_GAIN_I: model_cfg.gain_integ = data[10:0];
            REG_GAIN_D: model_cfg.gain_deriv = data[10:0];
            REG_WINDUP: model_cfg.windup_limit = data[14:0];
            REG_DAMP: model_cfg.damp_threshold = data[15:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic send_speed(input logic [15:0] speed);
        int gap;
        gap = (send_max_gap == 0) ? 0 : int'($urandom_range(0, send_max_gap));
        if (gap > 0)
        begin
            meas_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        meas_valid <= 1'b1;
        measured_speed <= speed;
        @(posedge clk);
        while (meas_stall)
        begin
            @(posedge clk);
        end
        pending_levels.push_back(next_drive_level(speed));
    endtask

    task automatic settle_idle();
        meas_valid <= 1'b0;
        while (pending_levels.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (IdleCycles) @(posedge clk);
    endtask

    task automatic test_reset_defaults();
        send_speed(16'd2000);
        send_speed(16'd1950);
        send_speed(16'd0);
        send_speed(16'd65535);
        send_speed(16'd2050);
    endtask

    task automatic test_register_map();
        settle_idle();
        write_reg(REG_TARGET, 4095);
        write_reg(RegSpareLo, 0);
        write_reg(RegSpareHi, 65535);
        send_speed(16'd2700);
        send_speed(16'd0);
        settle_idle();
        write_reg(REG_TARGET, 2701);
        send_speed(16'd2600);
        settle_idle();
        write_reg(REG_TARGET, 0);
        send_speed(16'd1);
    endtask

    task automatic test_special_cases();
        settle_idle();
        write_reg(REG_TARGET, 2700);
        write_reg(REG_GAIN_P, 0);
        write_reg(REG_GAIN_I, 1023);
        write_reg(REG_GAIN_D, 0);
        write_reg(REG_WINDUP, 0);
        send_speed(16'd0);
        send_speed(16'd0);
        settle_idle();
        write_reg(REG_GAIN_P, 1);
        write_reg(REG_GAIN_I, 0);
        write_reg(REG_DAMP, 0);
        send_speed(16'd2700);
        send_speed(16'd2699);
        settle_idle();
        write_reg(REG_DAMP, 65535);
        send_speed(16'd2703);
        send_speed(16'd2697);
        send_speed(16'd65535);
        settle_idle();
        write_reg(REG_GAIN_P, 1023);
        write_reg(REG_GAIN_I, 1023);
        write_reg(REG_WINDUP, 32767);
        send_speed(16'd0);
        send_speed(16'd0);
        settle_idle();
        write_reg(REG_GAIN_P, -1024);
        write_reg(REG_GAIN_I, -1024);
        write_reg(REG_GAIN_D, -1024);
        send_speed(16'd0);
        send_speed(16'd65535);
        settle_idle();
        write_reg(REG_GAIN_P, 0);
        write_reg(REG_GAIN_I, 0);
        write_reg(REG_GAIN_D, 1023);
        send_speed(16'd0);
    endtask

    task automatic test_random_tuning();
        int phase;
        int n;
        for (phase = 0; phase < RandomPhases; phase++)
        begin
            settle_idle();
            write_reg(REG_TARGET, pick_setting(0, 4095, 500, 2700));
            write_reg(REG_GAIN_P, pick_setting(-1024, 1023, -6, 6));
            write_reg(REG_GAIN_I, pick_setting(-1024, 1023, -6, 6));
            write_reg(REG_GAIN_D, pick_setting(-1024, 1023, -6, 6));
            write_reg(REG_WINDUP, pick_setting(0, 32767, 0, 2000));
            write_reg(REG_DAMP, pick_setting(0, 65535, 0, 400));
            send_max_gap = (phase % 5 == 2) ? 0 : MaxGap;
            recv_max_gap = (phase % 5 == 3) ? 0 : MaxGap;
            for (n = 0; n < PhaseRequests; n++)
            begin
                send_speed(random_speed());
            end
        end
        send_max_gap = MaxGap;
        recv_max_gap = MaxGap;
    endtask

    task automatic test_output_backpressure();
        int n;
        settle_idle();
        write_reg(REG_GAIN_P, 2);
        write_reg(REG_GAIN_I, 1);
        write_reg(REG_GAIN_D, -1);
        send_max_gap = 0;
        hold_request = HoldOffCycles;
        for (n = 0; n < BurstRequests; n++)
        begin
            send_speed(random_speed());
        end
        send_max_gap = MaxGap;
    endtask

    initial
    begin
        int pause;
        drive_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_request > 0)
            begin
                pause = hold_request;
                hold_request = 0;
            end
            else
            begin
                pause = (recv_max_gap == 0) ? 0 : int'($urandom_range(0, recv_max_gap));
            end
            if (pause > 0)
            begin
                drive_stall <= 1'b1;
                repeat (pause) @(posedge clk);
            end
            drive_stall <= 1'b0;
            @(posedge clk);
            while (!drive_valid)
            begin
                @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            cycle_count++;
            if (drive_valid && !drive_stall)
            begin
                if (pending_levels.size() == 0)
                begin
                    $display("%0t: unexpected drive_level, expected none, actual %0d",
                             $time, drive_level);
                    fault_count++;
                end
                else
                begin
                    want_level = pending_levels.pop_front();
                    if (drive_level !== want_level)
                    begin
                        $display("%0t: drive_level mismatch, expected %0d, actual %0d",
                                 $time, want_level, drive_level);
                        fault_count++;
                    end
                end
            end
            if (cycle_count > CycleLimit)
            begin
                $display("testbench: FAIL");
                $finish;
            end
        end
    end

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        meas_valid = 1'b0;
        measured_speed = '0;
        fault_count = 0;
        cycle_count = 0;
        send_max_gap = MaxGap;
        recv_max_gap = MaxGap;
        hold_request = 0;
        model_cfg.target_speed = TargetReset;
        model_cfg.gain_prop = GainPropReset;
        model_cfg.gain_integ = GainIntegReset;
        model_cfg.gain_deriv = GainDerivReset;
        model_cfg.windup_limit = WindupReset;
        model_cfg.damp_threshold = DampReset;
        model_integral = '0;
        model_last_error = '0;
        model_duty = LevelReset;
        repeat (ResetCycles) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_register_map();
        test_special_cases();
        test_random_tuning();
        test_output_backpressure();

        settle_idle();
        repeat (DrainCycles) @(posedge clk);
        if (fault_count == 0)
        begin
            $display("testbench: PASS");
        end
        else
        begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule
